### hw/rtl/dgts_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dgts_pkg
// Shared types and constants for the digraph cycle check / topological sort.
// ----------------------------------------------------------------------------
package dgts_pkg;

    localparam int DefMaxVertices = 64;
    localparam int DefMaxEdges    = 256;
    localparam int VtxW           = 6;
    localparam int CountW         = 7;
    localparam int OpW            = 3;
    localparam int StatusW        = 2;
    localparam int InDataW        = 16;
    localparam int OutDataW       = 16;

    localparam logic [OpW-1:0] OP_ADD    = 3'd0;
    localparam logic [OpW-1:0] OP_REMOVE = 3'd1;
    localparam logic [OpW-1:0] OP_CHECK  = 3'd2;
    localparam logic [OpW-1:0] OP_SORT   = 3'd3;
    localparam logic [OpW-1:0] OP_CLEAR  = 3'd4;

    localparam logic [StatusW-1:0] ST_OK    = 2'd0;
    localparam logic [StatusW-1:0] ST_RANGE = 2'd1;
    localparam logic [StatusW-1:0] ST_FULL  = 2'd2;
    localparam logic [StatusW-1:0] ST_EMPTY = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_REM_RD,
        S_REM_CHK,
        S_TRIM_RD,
        S_TRIM_CHK,
        S_CLR_MARKS,
        S_ROOT,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_POP,
        S_RESULT,
        S_EMIT_RD,
        S_EMIT
    } state_t;

endpackage
`default_nettype wire

### hw/rtl/digraph_cycle_check_topo_sort.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Add/clear answer directly; remove scans the edge slots down from the top. Check/sort
// clear the marks, then walk each root, scanning the edge slots of every visited
// vertex and popping the stack; sort then emits the finished vertices in turn. The
// edge memory has one read port, walked by the sequencer. One transaction at a time.
// Reset (aresetn low, synchronous): graph empty, vertex_count 64, idle.
// ----------------------------------------------------------------------------
// digraph_cycle_check_topo_sort
// Edge store in RAM, iterative DFS with explicit stack under a small sequencer.
// ----------------------------------------------------------------------------
module digraph_cycle_check_topo_sort #(
    parameter int MAX_VERTICES = dgts_pkg::DefMaxVertices,
    parameter int MAX_EDGES    = dgts_pkg::DefMaxEdges
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_we,
    input  wire logic [dgts_pkg::CountW-1:0]  cfg_wdata,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    // [2:0] opcode, [8:3] src_vertex, [14:9] dst_vertex, [15] zero
    input  wire logic [dgts_pkg::InDataW-1:0] s_tdata,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    // [1:0] status, [2] has_cycle, [8:3] order_vertex, [15:9] zero
    output logic [dgts_pkg::OutDataW-1:0]     m_tdata,
    output logic                              m_tlast
);
    import dgts_pkg::*;

    localparam int EW  = $clog2(MAX_EDGES);
    localparam int UW  = $clog2(MAX_EDGES + 1);
    localparam int VW  = (MAX_VERTICES > 64) ? VtxW : $clog2(MAX_VERTICES);
    localparam int SW  = $clog2(MAX_VERTICES + 1);
    localparam int VL  = (MAX_VERTICES < 64) ? MAX_VERTICES : 64;
    localparam int VLI = VL;

    // edge memory and stack memories
    logic [VtxW-1:0] esrc_mem [MAX_EDGES];
    logic [VtxW-1:0] edst_mem [MAX_EDGES];
    logic [MAX_EDGES-1:0] live_reg;
    logic [VtxW-1:0] stk_v_mem [VL];
    logic [UW-1:0]   stk_c_mem [VL];
    logic [VtxW-1:0] fin_mem   [VL];

    state_t state_reg, state_next;
    logic [CountW-1:0] vcnt_reg;
    logic [UW-1:0] used_reg;
    logic [VtxW:0] last_src_reg;      // msb set: none
    logic [VL-1:0] vis_reg, onp_reg;
    logic [OpW-1:0] op_reg;
    logic [UW-1:0] cur_reg;           // scan cursor / remove index
    logic [SW-1:0] sp_reg;
    logic [VtxW-1:0] v_reg;
    logic [VtxW:0] root_reg;
    logic [SW-1:0] fin_cnt_reg, emit_reg;
    logic [VtxW-1:0] rd_src_reg, rd_dst_reg, rd_stk_v_reg, rd_fin_reg;
    logic [UW-1:0] rd_stk_c_reg;
    logic [StatusW-1:0] ostat_reg;
    logic ocyc_reg, olast_reg, ovalid_reg;
    logic [VtxW-1:0] ovtx_reg;

    logic [CountW-1:0] n_eff;
    always_comb begin
        n_eff = vcnt_reg;
        if (n_eff == '0) n_eff = CountW'(1);
        if (n_eff > CountW'(VLI)) n_eff = CountW'(VLI);
    end

    logic [OpW-1:0]  in_op;
    logic [VtxW-1:0] in_src, in_dst;
    assign in_op  = s_tdata[2:0];
    assign in_src = s_tdata[8:3];
    assign in_dst = s_tdata[14:9];

    assign s_tready = (state_reg == S_IDLE) && !ovalid_reg;
    logic acc;
    assign acc = s_tvalid && s_tready;
    logic out_free;
    assign out_free = !ovalid_reg || m_tready;
    logic out_load;
    assign out_load = out_free && (state_reg inside {S_RESULT, S_EMIT});

    logic add_ok;
    assign add_ok = ({1'b0, in_src} < n_eff) && ({1'b0, in_dst} < n_eff)
                    && (used_reg != UW'(MAX_EDGES));

    logic [EW-1:0] cur_idx;
    assign cur_idx = cur_reg[EW-1:0];
    // remove looks one slot below the cursor while it steps down
    logic [EW-1:0] rd_idx;
    assign rd_idx = (state_reg == S_REM_RD) ? EW'(cur_reg - UW'(1)) : cur_idx;
    logic [VW-1:0] v_idx, t_idx;
    assign v_idx = v_reg[VW-1:0];
    assign t_idx = rd_dst_reg[VW-1:0];
    logic [SW-1:0] top;
    assign top = sp_reg - SW'(1);

    logic edge_hit;
    assign edge_hit = live_reg[cur_idx] && (rd_src_reg == v_reg)
                      && ({1'b0, rd_dst_reg} < n_eff);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (acc) begin
                    if (in_op == OP_REMOVE) state_next = S_REM_RD;
                    else if (in_op inside {OP_CHECK, OP_SORT}) state_next = S_CLR_MARKS;
                    else state_next = S_RESULT;
                end
            end
            S_REM_RD: begin
                if (last_src_reg[VtxW] || cur_reg == '0) state_next = S_RESULT;
                else state_next = S_REM_CHK;
            end
            S_REM_CHK: begin
                if (live_reg[cur_idx] && rd_src_reg == last_src_reg[VtxW-1:0])
                    state_next = S_TRIM_RD;
                else state_next = S_REM_RD;
            end
            S_TRIM_RD: state_next = S_TRIM_CHK;
            S_TRIM_CHK: begin
                if (used_reg == '0 || live_reg[EW'(used_reg - UW'(1))]) state_next = S_RESULT;
            end
            S_CLR_MARKS: state_next = S_ROOT;
            S_ROOT: begin
                if (root_reg >= n_eff) begin
                    state_next = (op_reg == OP_SORT) ? S_EMIT_RD : S_RESULT;
                end else if (!vis_reg[root_reg[VW-1:0]]) state_next = S_SCAN_RD;
            end
            S_SCAN_RD: state_next = (cur_reg >= used_reg) ? S_POP : S_SCAN_CHK;
            S_SCAN_CHK: begin
                if (edge_hit && vis_reg[t_idx] && onp_reg[t_idx] && op_reg == OP_CHECK)
                    state_next = S_RESULT;
                else state_next = S_SCAN_RD;
            end
            S_POP: state_next = (sp_reg == SW'(1)) ? S_ROOT : S_SCAN_RD;
            S_RESULT: if (out_free) state_next = S_IDLE;
            S_EMIT_RD: state_next = S_EMIT;
            S_EMIT: if (out_free) state_next = (emit_reg == SW'(1)) ? S_IDLE : S_EMIT_RD;
            default: state_next = S_IDLE;
        endcase
    end

    // memories
    always_ff @(posedge aclk) begin
        if (acc && in_op == OP_ADD && add_ok) begin
            esrc_mem[used_reg[EW-1:0]] <= in_src;
            edst_mem[used_reg[EW-1:0]] <= in_dst;
        end
        rd_src_reg <= esrc_mem[rd_idx];
        rd_dst_reg <= edst_mem[rd_idx];
    end

    logic stk_we;
    logic [VW-1:0] stk_wa;
    logic [VtxW-1:0] stk_wv;
    logic [UW-1:0] stk_wc;
    always_comb begin
        stk_we = 1'b0;
        stk_wa = '0;
        stk_wv = v_reg;
        stk_wc = cur_reg;
        if (state_reg == S_SCAN_CHK && edge_hit) begin
            stk_we = 1'b1;
            stk_wa = top[VW-1:0];
            stk_wc = cur_reg + UW'(1);
        end
    end
    always_ff @(posedge aclk) begin
        if (stk_we) begin
            stk_v_mem[stk_wa] <= stk_wv;
            stk_c_mem[stk_wa] <= stk_wc;
        end
        rd_stk_v_reg <= stk_v_mem[VW'(sp_reg - SW'(2))];
        rd_stk_c_reg <= stk_c_mem[VW'(sp_reg - SW'(2))];
        if (state_reg == S_POP) fin_mem[fin_cnt_reg[VW-1:0]] <= v_reg;
        rd_fin_reg <= fin_mem[VW'(emit_reg - SW'(1))];
    end

    // control / datapath
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            vcnt_reg     <= CountW'(64);
            used_reg     <= '0;
            last_src_reg <= {1'b1, {VtxW{1'b0}}};
            live_reg     <= '0;
            vis_reg      <= '0;
            onp_reg      <= '0;
            ovalid_reg   <= 1'b0;
            sp_reg       <= '0;
            fin_cnt_reg  <= '0;
            emit_reg     <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) vcnt_reg <= cfg_wdata;
            if (ovalid_reg && m_tready && !out_load) ovalid_reg <= 1'b0;
            case (state_reg)
                S_IDLE: begin
                    if (acc) begin
                        op_reg    <= in_op;
                        ocyc_reg  <= 1'b0;
                        ovtx_reg  <= '0;
                        olast_reg <= 1'b1;
                        cur_reg   <= used_reg;
                        if (in_op == OP_ADD) begin
                            if ({1'b0, in_src} >= n_eff || {1'b0, in_dst} >= n_eff)
                                ostat_reg <= ST_RANGE;
                            else if (used_reg == UW'(MAX_EDGES)) ostat_reg <= ST_FULL;
                            else begin
                                ostat_reg    <= ST_OK;
                                live_reg[used_reg[EW-1:0]] <= 1'b1;
                                used_reg     <= used_reg + UW'(1);
                                last_src_reg <= {1'b0, in_src};
                            end
                        end else begin
                            ostat_reg <= ST_OK;
                            if (in_op == OP_CLEAR) begin
                                live_reg     <= '0;
                                used_reg     <= '0;
                                last_src_reg <= {1'b1, {VtxW{1'b0}}};
                            end
                        end
                    end
                end
                S_REM_RD: begin
                    if (last_src_reg[VtxW] || cur_reg == '0) ostat_reg <= ST_EMPTY;
                    else cur_reg <= cur_reg - UW'(1);
                end
                S_REM_CHK: begin
                    if (live_reg[cur_idx] && rd_src_reg == last_src_reg[VtxW-1:0])
                        live_reg[cur_idx] <= 1'b0;
                end
                S_TRIM_CHK: begin
                    if (used_reg != '0 && !live_reg[EW'(used_reg - UW'(1))])
                        used_reg <= used_reg - UW'(1);
                end
                S_CLR_MARKS: begin
                    vis_reg     <= '0;
                    onp_reg     <= '0;
                    fin_cnt_reg <= '0;
                    root_reg    <= '0;
                end
                S_ROOT: begin
                    if (root_reg >= n_eff) begin
                        emit_reg <= fin_cnt_reg;
                        ocyc_reg <= 1'b0;
                    end else begin
                        if (!vis_reg[root_reg[VW-1:0]]) begin
                            vis_reg[root_reg[VW-1:0]] <= 1'b1;
                            onp_reg[root_reg[VW-1:0]] <= 1'b1;
                            v_reg   <= root_reg[VtxW-1:0];
                            cur_reg <= '0;
                            sp_reg  <= SW'(1);
                        end
                        root_reg <= root_reg + (VtxW+1)'(1);
                    end
                end
                S_SCAN_CHK: begin
                    if (edge_hit) begin
                        if (!vis_reg[t_idx]) begin
                            if (sp_reg < SW'(MAX_VERTICES)) begin
                                vis_reg[t_idx] <= 1'b1;
                                onp_reg[t_idx] <= 1'b1;
                                v_reg   <= rd_dst_reg;
                                cur_reg <= '0;
                                sp_reg  <= sp_reg + SW'(1);
                            end else cur_reg <= cur_reg + UW'(1);
                        end else begin
                            cur_reg <= cur_reg + UW'(1);
                            if (onp_reg[t_idx] && op_reg == OP_CHECK) ocyc_reg <= 1'b1;
                        end
                    end else cur_reg <= cur_reg + UW'(1);
                end
                S_POP: begin
                    onp_reg[v_idx] <= 1'b0;
                    fin_cnt_reg    <= fin_cnt_reg + SW'(1);
                    sp_reg         <= sp_reg - SW'(1);
                    v_reg          <= rd_stk_v_reg;
                    cur_reg        <= rd_stk_c_reg;
                end
                S_RESULT: begin
                    if (out_free) ovalid_reg <= 1'b1;
                end
                S_EMIT: begin
                    if (out_free) begin
                        ovalid_reg <= 1'b1;
                        ovtx_reg   <= rd_fin_reg;
                        olast_reg  <= (emit_reg == SW'(1));
                        emit_reg   <= emit_reg - SW'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    // stack read address follows sp; S_SCAN_RD stage leaves time for it
    assign m_tvalid = ovalid_reg;
    assign m_tlast  = olast_reg;
    assign m_tdata  = {7'd0, ovtx_reg, ocyc_reg, ostat_reg};

`ifndef NO_ASSERTIONS
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> state_reg == S_IDLE) else $error("ready outside idle");
    a_used_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= UW'(MAX_EDGES)) else $error("edge count overflow");
    a_sp_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        sp_reg <= SW'(MAX_VERTICES)) else $error("stack overflow");
`endif
endmodule
`default_nettype wire
